@@ src/icr_pkg.sv @@
package icr_pkg;

  localparam int unsigned SlotCount = 64;
  localparam int unsigned OpW       = 2;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned RefW      = 16;

  typedef enum logic [OpW-1:0] {
    OP_GET   = 2'd0,
    OP_FIND  = 2'd1,
    OP_PUT   = 2'd2,
    OP_DIRTY = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_NOFREE    = 3'd2,
    ST_FOUND     = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_UNDERFLOW = 3'd6,
    ST_MARKED    = 3'd7
  } status_e;

  typedef struct packed {
    logic            load;
    logic [KeyW-1:0] key;
    logic            inval;
    logic            refs_we;
    logic [RefW-1:0] refs;
    logic            dirty_we;
    logic            dirty;
  } slot_wr_t;

  typedef struct packed {
    logic push_head;
    logic push_tail;
    logic remove;
  } fl_cmd_t;

endpackage

@@ src/icr_if.sv @@
interface icr_in_if;
  logic                        valid;
  logic                        ready;
  logic [icr_pkg::OpW-1:0]     operation;
  logic [icr_pkg::KeyW-1:0]    object_key;
  logic [icr_pkg::IdxW-1:0]    slot_index;
  logic                        links_zero;

  modport source (output valid, operation, object_key, slot_index, links_zero, input ready);
  modport sink   (input valid, operation, object_key, slot_index, links_zero, output ready);
endinterface

interface icr_out_if;
  logic                        valid;
  logic                        ready;
  logic [icr_pkg::StatusW-1:0] status;
  logic [icr_pkg::IdxW-1:0]    result_slot;
  logic                        need_fetch;
  logic                        need_writeback;
  logic                        need_free;
  logic [icr_pkg::RefW-1:0]    ref_count;

  modport source (output valid, status, result_slot, need_fetch, need_writeback, need_free,
                  ref_count, input ready);
  modport sink   (input valid, status, result_slot, need_fetch, need_writeback, need_free,
                  ref_count, output ready);
endinterface

@@ src/icr_slot_cell.sv @@
module icr_slot_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [icr_pkg::KeyW-1:0] cmp_key_i,
  input  logic                     wr_en_i,
  input  icr_pkg::slot_wr_t        wr_i,
  output logic                     match_o,
  output logic                     valid_o,
  output logic                     dirty_o,
  output logic [icr_pkg::RefW-1:0] refs_o
);

  logic [icr_pkg::KeyW-1:0] key_q;
  logic                     valid_q;
  logic                     dirty_q;
  logic [icr_pkg::RefW-1:0] refs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      refs_q  <= '0;
    end else if (wr_en_i) begin
      if (wr_i.load) begin
        key_q   <= wr_i.key;
        valid_q <= 1'b1;
      end
      if (wr_i.inval) begin
        valid_q <= 1'b0;
      end
      if (wr_i.refs_we) begin
        refs_q <= wr_i.refs;
      end
      if (wr_i.dirty_we) begin
        dirty_q <= wr_i.dirty;
      end
    end
  end

  assign match_o = valid_q && (key_q == cmp_key_i);
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;
  assign refs_o  = refs_q;

endmodule

@@ src/icr_fl_cell.sv @@
module icr_fl_cell #(
  parameter int unsigned     SlotW     = 6,
  parameter logic [SlotW-1:0] ResetSlot = '0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  icr_pkg::fl_cmd_t cmd_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic             at_tail_i,
  input  logic [SlotW-1:0] prev_slot_i,
  input  logic             prev_valid_i,
  input  logic             prev_pull_i,
  input  logic [SlotW-1:0] next_slot_i,
  input  logic             next_valid_i,
  output logic [SlotW-1:0] slot_o,
  output logic             valid_o,
  output logic             settled_o
);

  logic [SlotW-1:0] slot_q;
  logic             valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= ResetSlot;
      valid_q <= 1'b1;
    end else if (cmd_i.push_head) begin
      slot_q  <= prev_slot_i;
      valid_q <= prev_valid_i;
    end else if (cmd_i.push_tail && at_tail_i) begin
      slot_q  <= slot_i;
      valid_q <= 1'b1;
    end else if (cmd_i.remove && valid_q && (slot_q == slot_i)) begin
      valid_q <= 1'b0;
    end else if (!valid_q) begin
      // hole moves one cell toward the tail
      slot_q  <= next_slot_i;
      valid_q <= next_valid_i;
    end else if (prev_pull_i) begin
      valid_q <= 1'b0;
    end
  end

  assign slot_o    = slot_q;
  assign valid_o   = valid_q;
  assign settled_o = valid_q || !next_valid_i;

endmodule

@@ src/inode_cache_refcount_lru.sv @@
// channel  dir  handshake      payload
// in_i     in   valid/ready    operation, object_key, slot_index, links_zero
// out_o    out  valid/ready    status, result_slot, need_fetch, need_writeback, need_free,
//                              ref_count
//
// one item at a time: transfer in, key match in the slot cells (S_MATCH), then update
// (S_EXEC), then the result waits in the output register until its transfer
// an item that unlinks a slot from the middle of the free-list row leaves a hole that
// walks one cell per cycle, so the next transfer in waits until the row has settled
// reset clears all slots at once
module inode_cache_refcount_lru #(
  parameter int unsigned SLOT_COUNT = icr_pkg::SlotCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  icr_in_if.sink    in_i,
  icr_out_if.source out_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned FW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned XW = SW + icr_pkg::IdxW;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC, S_DONE} state_e;

  state_e                      state_q;
  icr_pkg::op_e                op_q;
  logic [icr_pkg::KeyW-1:0]    key_q;
  logic [icr_pkg::IdxW-1:0]    idx_q;
  logic                        lz_q;
  logic [SLOT_COUNT-1:0]       sel_q;
  logic [FW-1:0]               fill_q;
  logic                        out_valid_q;
  logic [icr_pkg::StatusW-1:0] status_q;
  logic [icr_pkg::IdxW-1:0]    rslot_q;
  logic                        fetch_q, wb_q, fr_q;
  logic [icr_pkg::RefW-1:0]    refs_q;

  logic [SLOT_COUNT-1:0]       match, dec, sc_valid, sc_dirty, wr_en;
  logic [icr_pkg::RefW-1:0]    sc_refs [SLOT_COUNT];
  logic [SW-1:0]               fl_slot [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       fl_valid, fl_ok;
  logic                        settled, idx_ok;
  logic [XW-1:0]               idx_x, slot_x;

  logic [icr_pkg::RefW-1:0]    rd_refs, new_refs, refs_out;
  logic                        rd_dirty, hit, use_head, fetch, wb, fr, use_idx;
  logic [SW-1:0]               hit_slot, rslot, fl_tgt;
  icr_pkg::status_e            st;
  icr_pkg::slot_wr_t           wr;
  icr_pkg::fl_cmd_t            fl_cmd, fl_cmd_g;
  logic                        exec;

  assign idx_x   = {{SW{1'b0}}, idx_q};
  assign idx_ok  = idx_x < XW'(SLOT_COUNT);
  assign settled = &fl_ok;
  assign exec    = (state_q == S_EXEC);

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    assign dec[i]   = idx_x == XW'(i);
    assign wr_en[i] = exec && (use_head ? (fl_slot[0] == SW'(i)) : sel_q[i]);

    icr_slot_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmp_key_i (key_q),
      .wr_en_i   (wr_en[i]),
      .wr_i      (wr),
      .match_o   (match[i]),
      .valid_o   (sc_valid[i]),
      .dirty_o   (sc_dirty[i]),
      .refs_o    (sc_refs[i])
    );
  end

  assign fl_cmd_g = exec ? fl_cmd : '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_free
    logic [SW-1:0] prev_slot, next_slot;
    logic          prev_valid, prev_pull, next_valid;

    if (i == 0) begin : g_first
      assign prev_slot  = fl_tgt;
      assign prev_valid = 1'b1;
      assign prev_pull  = 1'b0;
    end else begin : g_mid
      assign prev_slot  = fl_slot[i-1];
      assign prev_valid = fl_valid[i-1];
      assign prev_pull  = !fl_valid[i-1];
    end
    if (i == SLOT_COUNT - 1) begin : g_last
      assign next_slot  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_slot  = fl_slot[i+1];
      assign next_valid = fl_valid[i+1];
    end

    icr_fl_cell #(
      .SlotW     (SW),
      .ResetSlot (SW'(i))
    ) u_fl (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (fl_cmd_g),
      .slot_i       (fl_tgt),
      .at_tail_i    (fill_q == FW'(i)),
      .prev_slot_i  (prev_slot),
      .prev_valid_i (prev_valid),
      .prev_pull_i  (prev_pull),
      .next_slot_i  (next_slot),
      .next_valid_i (next_valid),
      .slot_o       (fl_slot[i]),
      .valid_o      (fl_valid[i]),
      .settled_o    (fl_ok[i])
    );
  end

  // gather the selected slot
  always_comb begin
    rd_refs  = '0;
    rd_dirty = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (sel_q[i]) begin
        rd_refs  = rd_refs | sc_refs[i];
        rd_dirty = rd_dirty | sc_dirty[i];
        hit_slot = hit_slot | SW'(i);
      end
    end
  end

  assign hit = |sel_q;

  always_comb begin
    st       = icr_pkg::ST_HIT;
    rslot    = '0;
    use_idx  = 1'b0;
    use_head = 1'b0;
    fetch    = 1'b0;
    wb       = 1'b0;
    fr       = 1'b0;
    refs_out = '0;
    new_refs = '0;
    wr       = '0;
    fl_cmd   = '0;
    fl_tgt   = hit_slot;
    unique case (op_q)
      icr_pkg::OP_GET: begin
        if (hit) begin
          new_refs   = (&rd_refs) ? rd_refs : rd_refs + 1'b1;
          wr.refs_we = 1'b1;
          wr.refs    = new_refs;
          fl_cmd.remove = (rd_refs == '0);
          st       = icr_pkg::ST_HIT;
          rslot    = hit_slot;
          refs_out = new_refs;
        end else if (!fl_valid[0]) begin
          st = icr_pkg::ST_NOFREE;
        end else begin
          use_head      = 1'b1;
          wr.load       = 1'b1;
          wr.key        = key_q;
          wr.refs_we    = 1'b1;
          wr.refs       = icr_pkg::RefW'(1);
          fl_cmd.remove = 1'b1;
          fl_tgt        = fl_slot[0];
          st            = icr_pkg::ST_MISS;
          rslot         = fl_slot[0];
          fetch         = 1'b1;
          refs_out      = icr_pkg::RefW'(1);
        end
      end
      icr_pkg::OP_FIND: begin
        if (hit) begin
          st       = icr_pkg::ST_FOUND;
          rslot    = hit_slot;
          refs_out = rd_refs;
        end else begin
          st = icr_pkg::ST_ABSENT;
        end
      end
      icr_pkg::OP_PUT: begin
        use_idx = 1'b1;
        if (rd_refs == '0) begin
          st = icr_pkg::ST_UNDERFLOW;
        end else begin
          new_refs    = rd_refs - 1'b1;
          fr          = (new_refs == '0) && lz_q;
          wb          = rd_dirty || fr;
          wr.refs_we  = 1'b1;
          wr.refs     = new_refs;
          wr.dirty_we = 1'b1;
          wr.dirty    = 1'b0;
          if (new_refs == '0) begin
            wr.inval         = lz_q;
            fl_cmd.push_head = lz_q;
            fl_cmd.push_tail = !lz_q;
          end
          st       = icr_pkg::ST_RELEASED;
          refs_out = new_refs;
        end
      end
      icr_pkg::OP_DIRTY: begin
        use_idx     = 1'b1;
        wr.dirty_we = 1'b1;
        wr.dirty    = 1'b1;
        st          = icr_pkg::ST_MARKED;
        refs_out    = rd_refs;
      end
      default: st = icr_pkg::ST_HIT;
    endcase
  end

  assign slot_x = {{icr_pkg::IdxW{1'b0}}, rslot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= icr_pkg::OP_GET;
      key_q       <= '0;
      idx_q       <= '0;
      lz_q        <= 1'b0;
      sel_q       <= '0;
      fill_q      <= FW'(SLOT_COUNT);
      out_valid_q <= 1'b0;
      status_q    <= '0;
      rslot_q     <= '0;
      fetch_q     <= 1'b0;
      wb_q        <= 1'b0;
      fr_q        <= 1'b0;
      refs_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= icr_pkg::op_e'(in_i.operation);
            key_q   <= in_i.object_key;
            idx_q   <= in_i.slot_index;
            lz_q    <= in_i.links_zero;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          sel_q   <= (op_q == icr_pkg::OP_GET || op_q == icr_pkg::OP_FIND) ? match
                     : (idx_ok ? dec : '0);
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (fl_cmd.remove) begin
            fill_q <= fill_q - 1'b1;
          end else if (fl_cmd.push_head || fl_cmd.push_tail) begin
            fill_q <= fill_q + 1'b1;
          end
          status_q    <= st;
          rslot_q     <= use_idx ? idx_q : slot_x[icr_pkg::IdxW-1:0];
          fetch_q     <= fetch;
          wb_q        <= wb;
          fr_q        <= fr;
          refs_q      <= refs_out;
          out_valid_q <= 1'b1;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
          end
          if ((!out_valid_q || out_o.ready) && settled) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.result_slot    = rslot_q;
  assign out_o.need_fetch     = fetch_q;
  assign out_o.need_writeback = wb_q;
  assign out_o.need_free      = fr_q;
  assign out_o.ref_count      = refs_q;

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches more than one slot");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(fill_q) == $countones(fl_valid)))
    else $error("free count differs from free row");

  a_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> settled)
    else $error("update while free row still compacting");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (!in_i.ready && !out_valid_q))
    else $error("second item taken while one in flight");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (op_q == icr_pkg::OP_GET || op_q == icr_pkg::OP_FIND))
      |-> ((sel_q & ~sc_valid) == '0))
    else $error("key match on an invalid slot");

endmodule
